// ===== rtl/core/sbf_pkg.sv =====
`timescale 1ns / 1ps

package sbf_pkg;

    localparam int unsigned TX_DEPTH_DEF = 16;
    localparam int unsigned RX_DEPTH_DEF = 16;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        ACT_SEND      = 3'd0,
        ACT_RECEIVE   = 3'd1,
        ACT_XFER_DONE = 3'd2,
        ACT_CLEAR_RX  = 3'd3,
        ACT_CLEAR_TX  = 3'd4,
        ACT_READ_ERR  = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TX_FULL  = 2'd1,
        ST_RX_EMPTY = 2'd2,
        ST_OVERRUN  = 2'd3
    } t_status;

    // ring control for one action
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_ring_ctl;

    typedef struct packed {
        t_status status;
        t_byte   read_byte;
        logic    shift_start;
        t_byte   shift_byte;
        logic    event_rx_byte;
        logic    event_rx_now_full;
        logic    event_rx_dropped;
        logic    event_tx_empty;
        logic    rx_overflow_seen;
        logic    tx_busy;
    } t_result;

endpackage

// ===== rtl/core/sbf_if.sv =====
`timescale 1ns / 1ps

interface sbf_in_if import sbf_pkg::*; ();
    logic    valid;
    logic    ready;
    logic [2:0] action;
    t_byte   byte_in;

    modport source (output valid, output action, output byte_in, input ready);
    modport sink   (input valid, input action, input byte_in, output ready);
endinterface

interface sbf_out_if import sbf_pkg::*; ();
    logic    valid;
    logic    ready;
    logic [1:0] status;
    t_byte   read_byte;
    logic    shift_start;
    t_byte   shift_byte;
    logic    event_rx_byte;
    logic    event_rx_now_full;
    logic    event_rx_dropped;
    logic    event_tx_empty;
    logic    rx_overflow_seen;
    logic    tx_busy;

    modport source (
        output valid, output status, output read_byte, output shift_start,
        output shift_byte, output event_rx_byte, output event_rx_now_full,
        output event_rx_dropped, output event_tx_empty, output rx_overflow_seen,
        output tx_busy, input ready
    );
    modport sink (
        input valid, input status, input read_byte, input shift_start,
        input shift_byte, input event_rx_byte, input event_rx_now_full,
        input event_rx_dropped, input event_tx_empty, input rx_overflow_seen,
        input tx_busy, output ready
    );
endinterface

// ===== rtl/core/sbf_ring.sv =====
`timescale 1ns / 1ps

module sbf_ring import sbf_pkg::*; #(
    parameter int unsigned DEPTH = TX_DEPTH_DEF,
    parameter bit          HAS_SECOND = 1'b1,
    localparam int unsigned AW = $clog2(DEPTH),
    localparam int unsigned CW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ring_ctl     i_ctl,
    input  t_byte         i_wdata,
    output logic [CW-1:0] o_count,
    output t_byte         o_front,
    output t_byte         o_second
);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] w_addr_b;
    t_byte         r_mem [DEPTH];
    t_byte         r_rd_a, r_rd_b, r_fwd_data;
    logic          r_fwd_a, r_fwd_b;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] idx);
        f_next = (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count + CW'(i_ctl.push) - CW'(i_ctl.pop);
        if (i_ctl.push) begin
            n_head = f_next(r_head);
        end
        if (i_ctl.pop) begin
            n_tail = f_next(r_tail);
        end
        if (i_ctl.clear) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end
    end

    assign w_addr_b = f_next(n_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            // bypass a word written this cycle to a prefetched slot
            r_fwd_a <= i_ctl.push && (r_head == n_tail);
            r_fwd_b <= i_ctl.push && (r_head == w_addr_b);
        end
    end

    // prefetch the oldest and the next oldest word every cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_head] <= i_wdata;
        end
        r_rd_a     <= r_mem[n_tail];
        r_rd_b     <= r_mem[w_addr_b];
        r_fwd_data <= i_wdata;
    end

    assign o_count = r_count;
    assign o_front = r_fwd_a ? r_fwd_data : r_rd_a;

    if (HAS_SECOND) begin : g_second
        assign o_second = r_fwd_b ? r_fwd_data : r_rd_b;
    end else begin : g_no_second
        assign o_second = '0;
    end

endmodule

// ===== rtl/core/spi_buffered_tx_rx_fifo.sv =====
`timescale 1ns / 1ps
// Pipeline: an accepted word passes the input register, then the result
//   register; it waits in the input register while the result is not taken.
// Throughput: one word per cycle unless the result side stalls; all work is
//   one pass of ring and flag logic between the two registers, the ring heads
//   being prefetched from the stores.
// Reset: synchronous, active low; clears ring pointers, counts and flags.
//   Ring stores are not cleared.

module spi_buffered_tx_rx_fifo import sbf_pkg::*; #(
    parameter int unsigned TX_DEPTH = TX_DEPTH_DEF,
    parameter int unsigned RX_DEPTH = RX_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbf_in_if.sink     i_in,
    sbf_out_if.source  o_out
);

    localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);
    localparam int unsigned RX_CW = $clog2(RX_DEPTH + 1);

    // input register
    logic       r_in_valid;
    logic [2:0] r_action;
    t_byte      r_byte;

    // result register
    logic       r_out_valid;
    t_result    r_res, n_res;

    // control flags
    logic       r_running, n_running;
    logic       r_rx_full_flag, n_rx_full_flag;
    logic       r_sticky, n_sticky;

    logic       w_advance, w_fire;
    t_ring_ctl  w_tx_ctl, w_rx_ctl;
    logic [TX_CW-1:0] w_tx_count;
    logic [RX_CW-1:0] w_rx_count;
    t_byte      w_tx_front, w_tx_second, w_rx_front;
    logic       w_tx_full, w_rx_full;

    // advance whenever the result register is free or being taken
    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;

    assign w_tx_full = (w_tx_count == TX_CW'(TX_DEPTH));
    assign w_rx_full = (w_rx_count == RX_CW'(RX_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_action <= i_in.action;
            r_byte   <= i_in.byte_in;
        end
    end

    // one action: ring moves, flag updates and the result word
    always_comb begin
        w_tx_ctl       = '0;
        w_rx_ctl       = '0;
        n_running      = r_running;
        n_rx_full_flag = r_rx_full_flag;
        n_sticky       = r_sticky;
        n_res          = '0;
        n_res.status   = ST_OK;

        case (r_action)
            ACT_SEND: begin
                if (w_tx_full) begin
                    n_res.status = ST_TX_FULL;
                end else begin
                    w_tx_ctl.push = w_fire;
                    if (!r_running) begin
                        // empty ring: the oldest word is the one just queued
                        n_res.shift_start = 1'b1;
                        n_res.shift_byte  = (w_tx_count == '0) ? r_byte : w_tx_front;
                        n_running         = 1'b1;
                    end
                end
            end
            ACT_RECEIVE: begin
                if (w_rx_count == '0) begin
                    n_res.status = ST_RX_EMPTY;
                end else begin
                    w_rx_ctl.pop    = w_fire;
                    n_res.read_byte = w_rx_front;
                    n_res.status    = r_rx_full_flag ? ST_OVERRUN : ST_OK;
                    n_rx_full_flag  = 1'b0;
                end
            end
            ACT_XFER_DONE: begin
                if (!w_rx_full) begin
                    w_rx_ctl.push           = w_fire;
                    n_res.event_rx_byte     = 1'b1;
                    n_res.event_rx_now_full = (w_rx_count == RX_CW'(RX_DEPTH - 1));
                end else begin
                    // drop the shifted-in word, remember it
                    n_rx_full_flag         = 1'b1;
                    n_sticky               = 1'b1;
                    n_res.event_rx_dropped = 1'b1;
                end
                // retire one word; start the next if one remains
                w_tx_ctl.pop = w_fire && (w_tx_count != '0);
                if (w_tx_count > TX_CW'(1)) begin
                    n_res.shift_start = 1'b1;
                    n_res.shift_byte  = w_tx_second;
                end else begin
                    n_running            = 1'b0;
                    n_res.event_tx_empty = 1'b1;
                end
            end
            ACT_CLEAR_RX: begin
                w_rx_ctl.clear = w_fire;
                n_rx_full_flag = 1'b0;
            end
            ACT_CLEAR_TX: begin
                // shifter keeps running until its transfer completes
                w_tx_ctl.clear = w_fire;
            end
            ACT_READ_ERR: begin
                n_res.rx_overflow_seen = r_sticky;
                n_sticky               = 1'b0;
            end
            default: begin
            end
        endcase

        n_res.tx_busy = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_running      <= 1'b0;
            r_rx_full_flag <= 1'b0;
            r_sticky       <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_running      <= n_running;
                r_rx_full_flag <= n_rx_full_flag;
                r_sticky       <= n_sticky;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= n_res;
        end
    end

    sbf_ring #(
        .DEPTH      (TX_DEPTH),
        .HAS_SECOND (1'b1)
    ) u_tx_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_tx_ctl),
        .i_wdata  (r_byte),
        .o_count  (w_tx_count),
        .o_front  (w_tx_front),
        .o_second (w_tx_second)
    );

    sbf_ring #(
        .DEPTH      (RX_DEPTH),
        .HAS_SECOND (1'b0)
    ) u_rx_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_rx_ctl),
        .i_wdata  (r_byte),
        .o_count  (w_rx_count),
        .o_front  (w_rx_front),
        .o_second ()
    );

    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_res.status;
    assign o_out.read_byte         = r_res.read_byte;
    assign o_out.shift_start       = r_res.shift_start;
    assign o_out.shift_byte        = r_res.shift_byte;
    assign o_out.event_rx_byte     = r_res.event_rx_byte;
    assign o_out.event_rx_now_full = r_res.event_rx_now_full;
    assign o_out.event_rx_dropped  = r_res.event_rx_dropped;
    assign o_out.event_tx_empty    = r_res.event_tx_empty;
    assign o_out.rx_overflow_seen  = r_res.rx_overflow_seen;
    assign o_out.tx_busy           = r_res.tx_busy;

    // an idle shifter implies an empty transmit ring
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (w_tx_count == '0))
        else $error("shifter idle with words queued");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tx_count <= TX_CW'(TX_DEPTH)) && (w_rx_count <= RX_CW'(RX_DEPTH)))
        else $error("ring count beyond depth");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.shift_start) |-> r_res.tx_busy)
        else $error("shifter started but not busy");

    a_drop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_res.event_rx_dropped) |=> r_sticky)
        else $error("dropped word not recorded");

endmodule

// ===== tb/tb_spi_buffered_tx_rx_fifo.sv =====
`timescale 1ns / 1ps

module tb_spi_buffered_tx_rx_fifo;
    import sbf_pkg::*;

    localparam int unsigned TX_N         = TX_DEPTH_DEF;
    localparam int unsigned RX_N         = RX_DEPTH_DEF;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned DRAIN_CYCLES = 8;

    // action codes the block has no meaning for; it must ignore them
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    logic i_clk;
    logic i_rst_n;

    sbf_in_if  in_bus ();
    sbf_out_if out_bus ();

    spi_buffered_tx_rx_fifo dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Shadow copy of the ring state, advanced once per accepted word
    t_byte       tx_ring [TX_N];
    t_byte       rx_ring [RX_N];
    int unsigned tx_wr, tx_rd, tx_fill;
    int unsigned rx_wr, rx_rd, rx_fill;
    bit          shifting;
    bit          dropped_since_pop;
    bit          overflow_sticky;

    t_result     pending_results [$];
    int unsigned fail_count;
    bit          idle_enabled;
    int unsigned hold_requests;
    int unsigned hold_served;
    int unsigned hold_left;
    int unsigned quiet_cycles;

    // Clock: 2 ns period
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Work out the result of one action and advance the shadow rings.
    function automatic t_result predict_action(input logic [2:0] act, input t_byte b);
        t_result r;
        r        = '0;
        r.status = ST_OK;
        case (act)
            ACT_SEND: begin
                if (tx_fill == TX_N) begin
                    r.status = ST_TX_FULL;
                end else begin
                    tx_ring[tx_wr] = b;
                    tx_wr          = (tx_wr + 1) % TX_N;
                    tx_fill++;
                    // idle shifter picks up the oldest queued byte at once
                    if (!shifting) begin
                        r.shift_start = 1'b1;
                        r.shift_byte  = tx_ring[tx_rd];
                        shifting      = 1'b1;
                    end
                end
            end
            ACT_RECEIVE: begin
                if (rx_fill == 0) begin
                    r.status = ST_RX_EMPTY;
                end else begin
                    r.read_byte = rx_ring[rx_rd];
                    rx_rd       = (rx_rd + 1) % RX_N;
                    rx_fill--;
                    r.status          = dropped_since_pop ? ST_OVERRUN : ST_OK;
                    dropped_since_pop = 1'b0;
                end
            end
            ACT_XFER_DONE: begin
                if (rx_fill < RX_N) begin
                    rx_ring[rx_wr] = b;
                    rx_wr          = (rx_wr + 1) % RX_N;
                    rx_fill++;
                    r.event_rx_byte     = 1'b1;
                    r.event_rx_now_full = (rx_fill == RX_N);
                end else begin
                    dropped_since_pop  = 1'b1;
                    overflow_sticky    = 1'b1;
                    r.event_rx_dropped = 1'b1;
                end
                // retire the byte just shifted; count holds at zero
                if (tx_fill > 0) begin
                    tx_fill--;
                    tx_rd = (tx_rd + 1) % TX_N;
                end
                if (tx_fill > 0) begin
                    r.shift_start = 1'b1;
                    r.shift_byte  = tx_ring[tx_rd];
                end else begin
                    shifting         = 1'b0;
                    r.event_tx_empty = 1'b1;
                end
            end
            ACT_CLEAR_RX: begin
                rx_fill           = 0;
                rx_wr             = 0;
                rx_rd             = 0;
                dropped_since_pop = 1'b0;
            end
            ACT_CLEAR_TX: begin
                // shifter keeps running until its transfer completes
                tx_fill = 0;
                tx_wr   = 0;
                tx_rd   = 0;
            end
            ACT_READ_ERR: begin
                r.rx_overflow_seen = overflow_sticky;
                overflow_sticky    = 1'b0;
            end
            default: begin
            end
        endcase
        r.tx_busy = shifting;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Offer one word at the falling edge and hold it until accepted.
    task automatic send_word(input logic [2:0] act, input t_byte b);
        int unsigned gap;
        if (idle_enabled && $urandom_range(0, 99) < 5) begin
            gap = $urandom_range(1, 3);
            repeat (gap) begin
                @(negedge i_clk);
                in_bus.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        in_bus.valid   <= 1'b1;
        in_bus.action  <= act;
        in_bus.byte_in <= b;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        pending_results.push_back(predict_action(act, b));
    endtask

    function automatic logic [2:0] pick_action();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return ACT_SEND;
        if (roll < 55) return ACT_XFER_DONE;
        if (roll < 80) return ACT_RECEIVE;
        if (roll < 85) return ACT_CLEAR_RX;
        if (roll < 90) return ACT_CLEAR_TX;
        if (roll < 95) return ACT_READ_ERR;
        return $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
    endfunction

    // Byte extremes, empty-ring cases, clear while shifting, spare codes.
    task automatic test_directed();
        send_word(ACT_RECEIVE,   8'h00);    // receive ring empty
        send_word(ACT_READ_ERR,  8'h00);    // no overflow yet
        send_word(ACT_XFER_DONE, 8'h00);    // transfer done, nothing queued
        send_word(ACT_SEND,      8'hFF);    // starts the shifter
        send_word(ACT_SEND,      8'h00);
        send_word(ACT_SEND,      8'hA5);
        send_word(ACT_XFER_DONE, 8'hFF);    // next byte handed on
        send_word(ACT_RECEIVE,   8'h00);
        send_word(ACT_RECEIVE,   8'h00);
        send_word(ACT_CLEAR_TX,  8'h00);    // empty ring, shifter still busy
        send_word(ACT_SEND,      8'h3C);    // queued, no start
        send_word(ACT_XFER_DONE, 8'h5A);    // retires 3C, ring drained
        send_word(ACT_XFER_DONE, 8'h81);
        send_word(ACT_CLEAR_RX,  8'h00);
        send_word(ACT_RECEIVE,   8'hFF);
        send_word(ACT_SPARE_A,   8'hFF);
        send_word(ACT_SPARE_B,   8'h00);
        send_word(ACT_SEND,      8'h7E);
        send_word(ACT_XFER_DONE, 8'h7E);
        send_word(ACT_RECEIVE,   8'h00);
    endtask

    // Random episodes: fill bursts drive both rings past full, drains pop
    // the receive ring through overrun, the rest is mixed traffic.
    task automatic test_random(input int unsigned n_items);
        int unsigned done;
        int unsigned kind;
        int unsigned len;
        logic [2:0]  act;
        done = 0;
        while (done < n_items) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(17, 20);
            case (kind)
                0, 1: begin
                    repeat (len) send_word(ACT_SEND, t_byte'($urandom));
                    done += len;
                end
                2, 3: begin
                    repeat (len) send_word(ACT_XFER_DONE, t_byte'($urandom));
                    done += len;
                end
                4: begin
                    len = $urandom_range(1, 18);
                    repeat (len) send_word(ACT_RECEIVE, t_byte'($urandom));
                    done += len;
                end
                default: begin
                    repeat (8) begin
                        act = pick_action();
                        send_word(act, t_byte'($urandom));
                        if (act != ACT_SPARE_A && act != ACT_SPARE_B) done++;
                    end
                end
            endcase
        end
    endtask

    // Long run with neither side idling.
    task automatic test_back_to_back();
        idle_enabled = 1'b0;
        test_random(100);
        idle_enabled = 1'b1;
    endtask

    // Receiver holds off while words keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_requests++;
        repeat (40) send_word(pick_action(), t_byte'($urandom));
    endtask

    // Result side: ready at the falling edge, with random stalls and a
    // long hold-off counted here on request.
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else if (idle_enabled) begin
            out_bus.ready <= ($urandom_range(0, 99) >= 10);
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation waiting");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status",            8'(want.status),            8'(out_bus.status));
                check_field("read_byte",         want.read_byte,             out_bus.read_byte);
                check_field("shift_start",       8'(want.shift_start),
                            8'(out_bus.shift_start));
                check_field("shift_byte",        want.shift_byte,            out_bus.shift_byte);
                check_field("event_rx_byte",     8'(want.event_rx_byte),
                            8'(out_bus.event_rx_byte));
                check_field("event_rx_now_full", 8'(want.event_rx_now_full),
                            8'(out_bus.event_rx_now_full));
                check_field("event_rx_dropped",  8'(want.event_rx_dropped),
                            8'(out_bus.event_rx_dropped));
                check_field("event_tx_empty",    8'(want.event_tx_empty),
                            8'(out_bus.event_tx_empty));
                check_field("rx_overflow_seen",  8'(want.rx_overflow_seen),
                            8'(out_bus.rx_overflow_seen));
                check_field("tx_busy",           8'(want.tx_busy),           8'(out_bus.tx_busy));
            end
        end
    end

    // Drop the run if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        tx_wr             = 0;
        tx_rd             = 0;
        tx_fill           = 0;
        rx_wr             = 0;
        rx_rd             = 0;
        rx_fill           = 0;
        shifting          = 1'b0;
        dropped_since_pop = 1'b0;
        overflow_sticky   = 1'b0;
        fail_count        = 0;
        idle_enabled      = 1'b1;
        hold_requests     = 0;
        hold_served       = 0;
        hold_left         = 0;
        quiet_cycles      = 0;

        i_rst_n        = 1'b0;
        in_bus.valid   = 1'b0;
        in_bus.action  = ACT_SEND;
        in_bus.byte_in = 8'h00;
        out_bus.ready  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(160);
        test_back_to_back();
        test_backpressure();
        test_random(100);

        @(negedge i_clk);
        in_bus.valid <= 1'b0;

        // drain, then give a stray word time to show up
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sbf_pkg.sv
rtl/core/sbf_if.sv
rtl/core/sbf_ring.sv
rtl/core/spi_buffered_tx_rx_fifo.sv
tb/tb_spi_buffered_tx_rx_fifo.sv
